// ----- src/keypad_code_lock_core_macros.svh -----
// Assertion macros shared by the keypad code lock checkers.
// Each macro expects a signal named clk, and all but KCL_ASSERT_NXT_RST also rst_n, in the scope where it is used.
`ifndef KEYPAD_CODE_LOCK_CORE_MACROS_SVH
`define KEYPAD_CODE_LOCK_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define KCL_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("keypad code lock assertion failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define KCL_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("keypad code lock assertion failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define KCL_ASSERT_NXT_RST(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) (ant) |=> (cons)) \
    else $error("keypad code lock assertion failed");

`endif

// ----- src/kcl_pkg.sv -----
// Shared constants and types for the keypad code lock.
// No dependencies; used by kcl_engine and keypad_code_lock_core.
package kcl_pkg;

  localparam int CODE_DIGITS_DEF = 6;
  localparam int KEY_W = 4;
  localparam int TIMEOUT_W = 16;
  localparam int DIGITS_OUT_W = 3;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [TIMEOUT_W-1:0] IDLE_MAX = 16'hFFFF;

  localparam logic REQ_KEY = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [KEY_W-1:0] KEY_CLEAR = 4'd10;
  localparam logic [KEY_W-1:0] KEY_CHANGE = 4'd11;
  localparam logic [KEY_W-1:0] KEY_ENTER = 4'd12;

  // Packed so that the last result field, unlocked, sits in the lowest bit.
  typedef struct packed {
    logic code_saved;
    logic wrong_code_seen;
    logic [DIGITS_OUT_W-1:0] digits_entered;
    logic change_mode;
    logic entry_mode;
    logic unlocked;
  } kcl_status_t;

endpackage

// ----- src/kcl_engine.sv -----
// Lock state and its combinational update for one key event or timer tick.
// Depends on kcl_pkg.
module kcl_engine import kcl_pkg::*; #(
  parameter int CODE_DIGITS = CODE_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [TIMEOUT_W-1:0] cfg_wr_data,
  input  logic                 item_fire,
  input  logic                 req_type,
  input  logic [KEY_W-1:0]     key_code,
  output kcl_status_t          status_nxt
);

  localparam int CNT_W = $clog2(CODE_DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_DIGITS);

  logic [CODE_DIGITS-1:0][KEY_W-1:0] entry_r;
  logic [CODE_DIGITS-1:0][KEY_W-1:0] code_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 ea_r, ea_nxt;
  logic                 ca_r, ca_nxt;
  logic                 unl_r, unl_nxt;
  logic                 wrong_r, wrong_nxt;
  logic [TIMEOUT_W-1:0] idle_r, idle_nxt;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [TIMEOUT_W-1:0] idle_inc;
  logic [CODE_DIGITS-1:0] entry_wr;
  logic                 digit_wr;
  logic                 code_wr;
  logic                 full;
  logic                 match;

  assign full = (cnt_r == CNT_FULL);
  assign match = (entry_r == code_r);
  assign idle_inc = (idle_r != IDLE_MAX) ? idle_r + 16'd1 : idle_r;

  always_comb begin
    cnt_nxt = cnt_r;
    ea_nxt = ea_r;
    ca_nxt = ca_r;
    unl_nxt = unl_r;
    wrong_nxt = wrong_r;
    idle_nxt = idle_r;
    digit_wr = 1'b0;
    code_wr = 1'b0;
    if (req_type == REQ_TICK) begin
      if (idle_inc >= timeout_r) begin
        unl_nxt = 1'b0;
        idle_nxt = '0;
      end else begin
        idle_nxt = idle_inc;
      end
    end else if (key_code <= KEY_ENTER) begin
      idle_nxt = '0;
      case (key_code)
        KEY_CLEAR: begin
          if (ea_r && !full) begin
            cnt_nxt = '0;
          end
        end
        KEY_CHANGE: begin
          if (unl_r) begin
            ca_nxt = 1'b1;
          end
          if ((ca_r || unl_r) && full) begin
            code_wr = 1'b1;
            ca_nxt = 1'b0;
            unl_nxt = 1'b1;
            cnt_nxt = '0;
          end
        end
        KEY_ENTER: begin
          ea_nxt = 1'b1;
          if (full) begin
            unl_nxt = match;
            wrong_nxt = wrong_r | !match;
            ea_nxt = 1'b0;
            cnt_nxt = '0;
          end
        end
        default: begin
          if ((ea_r || ca_r) && !full) begin
            digit_wr = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      entry_wr[i] = digit_wr && (cnt_r == CNT_W'(i));
    end
  end

  always_comb begin
    status_nxt.unlocked = unl_nxt;
    status_nxt.entry_mode = ea_nxt;
    status_nxt.change_mode = ca_nxt;
    status_nxt.digits_entered = DIGITS_OUT_W'(cnt_nxt);
    status_nxt.wrong_code_seen = wrong_nxt;
    status_nxt.code_saved = code_wr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ea_r <= 1'b0;
      ca_r <= 1'b0;
      unl_r <= 1'b0;
      wrong_r <= 1'b0;
      idle_r <= '0;
      code_r <= '0;
    end else if (item_fire) begin
      cnt_r <= cnt_nxt;
      ea_r <= ea_nxt;
      ca_r <= ca_nxt;
      unl_r <= unl_nxt;
      wrong_r <= wrong_nxt;
      idle_r <= idle_nxt;
      if (code_wr) begin
        code_r <= entry_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (item_fire && entry_wr[i]) begin
        entry_r[i] <= key_code;
      end
    end
  end

endmodule

// ----- src/keypad_code_lock_core.sv -----
// Keypad code lock: one result transfer per input transfer, through an input register
// and then a result register holding the updated lock state.
// Throughput is one item per cycle while out_tready is high; the input register refills while a result waits.
// Synchronous active-low reset relocks, empties the entry, zeroes the stored code
// and sets the idle timeout to 5000 ticks.
// Depends on kcl_pkg and kcl_engine.
module keypad_code_lock_core import kcl_pkg::*; #(
  parameter int CODE_DIGITS = CODE_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [TIMEOUT_W-1:0] cfg_wr_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [3:0] key_code, [7:4] zero
  input  logic                 in_tuser,   // [0] req_type
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata   // [0] unlocked, [1] entry_mode,
                                           // [2] change_mode, [5:3] digits_entered,
                                           // [6] wrong_code_seen, [7] code_saved
);

  logic              in_vld_r;
  logic              in_req_r;
  logic [KEY_W-1:0]  in_key_r;
  logic              out_vld_r;
  kcl_status_t       out_data_r;
  kcl_status_t       status_nxt;
  logic              adv;
  logic              fire;

  assign adv = !out_vld_r || out_tready;
  assign fire = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;
  assign out_tvalid = out_vld_r;
  assign out_tdata = out_data_r;

  kcl_engine #(
    .CODE_DIGITS(CODE_DIGITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .item_fire  (fire),
    .req_type   (in_req_r),
    .key_code   (in_key_r),
    .status_nxt (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_req_r <= in_tuser;
      in_key_r <= in_tdata[KEY_W-1:0];
    end
    if (fire) begin
      out_data_r <= status_nxt;
    end
  end

endmodule

// ----- src/kcl_checker.sv -----
// Port-level assertions for keypad_code_lock_core and the bind that attaches them.
// Depends on keypad_code_lock_core_macros.svh.
`include "keypad_code_lock_core_macros.svh"

module kcl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  `KCL_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `KCL_ASSERT_IMP(a_saved_state, out_tvalid && out_tdata[7], out_tdata[0] && !out_tdata[2] && (out_tdata[5:3] == 3'd0))
  `KCL_ASSERT_NXT(a_wrong_sticky, out_tvalid && out_tready && out_tdata[6], !out_tvalid || out_tdata[6])
  `KCL_ASSERT_NXT_RST(a_reset_empty, !rst_n, !out_tvalid)

endmodule

bind keypad_code_lock_core kcl_checker u_kcl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
